// ----- rtl/assert_macros.svh -----
// assertion macros used by disjoint_interval_table.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dit_pkg.sv -----
// types and codes for the disjoint interval table
`timescale 1ns / 1ps
`default_nettype none
package dit_pkg;

  // operation codes
  localparam logic [2:0] FUNC_FILL      = 3'd0;
  localparam logic [2:0] FUNC_CLEAR     = 3'd1;
  localparam logic [2:0] FUNC_CHK_POINT = 3'd2;
  localparam logic [2:0] FUNC_CHK_ANY   = 3'd3;
  localparam logic [2:0] FUNC_CHK_ALL   = 3'd4;

  // status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_BOUNDS  = 2'd2;

  // source of a rewritten entry
  typedef enum logic [1:0] {
    SRC_ENTRY  = 2'd0,  // stored entry unchanged
    SRC_MERGED = 2'd1,  // merged fill interval
    SRC_LEFT   = 2'd2,  // [s, lo]
    SRC_RIGHT  = 2'd3   // [hi, e]
  } src_e;

  // per-entry decision of the step logic
  typedef struct packed {
    logic wr0;
    src_e src0;
    logic wr1;
    src_e src1;
    logic merge;
    logic place;
    logic hit;
  } step_t;

endpackage
`default_nettype wire

// ----- rtl/disjoint_interval_table.sv -----
// disjoint interval table: sequencer around a two-bank interval memory
// each stored interval is read from memory (S_RD) and then updated (S_PROC); a split
// or a placed fill interval adds a second write (S_WR2) for that entry
// one item is worked at a time; a new request is taken while the result waits
// updates write into the spare bank and switch banks only on success
// reset empties the table at once; memory contents need no clearing
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module disjoint_interval_table #(
  parameter int MAX_RANGES  = 16,
  parameter int COORD_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,  // lo [31:0], hi [63:32]
  input  wire logic [2:0]  s_axis_tuser_i,  // func
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // answer [0], status [2:1], entries_used [3+CNT_W-1:3], zero pad
  output logic [(((3 + $clog2(MAX_RANGES + 1)) + 7) / 8) * 8 - 1:0] m_axis_tdata_o
);
  import dit_pkg::*;

  localparam int CNT_W  = $clog2(MAX_RANGES + 1);
  localparam int N_W    = $clog2(MAX_RANGES + 2);
  localparam int IDX_W  = $clog2(MAX_RANGES);
  localparam int DEPTH  = 2 * (1 << IDX_W);
  localparam int OUT_W  = 3 + CNT_W;
  localparam int TD_W   = ((OUT_W + 7) / 8) * 8;
  localparam int CW     = COORD_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_PROC = 3'd2;
  localparam logic [2:0] S_WR2  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [2:0]       func_q, func_d;
  logic [CW-1:0]    lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0]    ms_q, ms_d, me_q, me_d;
  logic             placed_q, placed_d;
  logic             hit_q, hit_d;
  logic             upd_q, upd_d;
  logic [1:0]       rej_q, rej_d;
  logic [N_W-1:0]   idx_q, idx_d, n_q, n_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             bank_q, bank_d;
  logic [2*CW-1:0]  wr2_q, wr2_d;
  logic             out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_q, out_d;

  logic [2*CW-1:0]  mem [DEPTH];
  logic [2*CW-1:0]  rdata_q;
  logic             re, we;
  logic [IDX_W:0]   raddr, waddr;
  logic [2*CW-1:0]  wdata;

  logic [CW-1:0]    in_lo, in_hi, s_w, e_w;
  logic             in_acc, out_free, upd_ok;
  step_t            step;

  assign in_lo  = CW'(s_axis_tdata_i[31:0]);
  assign in_hi  = CW'(s_axis_tdata_i[63:32]);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign s_w    = rdata_q[CW-1:0];
  assign e_w    = rdata_q[2*CW-1:CW];
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign upd_ok = (n_q <= N_W'(MAX_RANGES));

  dit_step #(.COORD_WIDTH(CW)) u_step (
    .func_i   (func_q),
    .lo_i     (lo_q),
    .hi_i     (hi_q),
    .placed_i (placed_q),
    .s_i      (s_w),
    .e_i      (e_w),
    .step_o   (step)
  );

  // pick rewritten interval from its source
  function automatic logic [2*CW-1:0] pick(src_e src, logic [CW-1:0] s, logic [CW-1:0] e,
                                          logic [CW-1:0] ms, logic [CW-1:0] me,
                                          logic [CW-1:0] lo, logic [CW-1:0] hi);
    logic [2*CW-1:0] r;
    unique case (src)
      SRC_ENTRY:  r = {e, s};
      SRC_MERGED: r = {me, ms};
      SRC_LEFT:   r = {lo, s};
      SRC_RIGHT:  r = {e, hi};
      default:    r = {e, s};
    endcase
    return r;
  endfunction

  // sequencer
  always_comb begin
    state_d = state_q;
    func_d = func_q; lo_d = lo_q; hi_d = hi_q;
    ms_d = ms_q; me_d = me_q; placed_d = placed_q; hit_d = hit_q;
    upd_d = upd_q; rej_d = rej_q; idx_d = idx_q; n_d = n_q;
    count_d = count_q; bank_d = bank_q; wr2_d = wr2_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_d = out_q;
    re = 1'b0; we = 1'b0; wdata = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          func_d = s_axis_tuser_i; lo_d = in_lo; hi_d = in_hi;
          ms_d = in_lo; me_d = in_hi; placed_d = 1'b0; hit_d = 1'b0;
          idx_d = '0; n_d = '0; rej_d = STATUS_OK;
          upd_d = (s_axis_tuser_i == FUNC_FILL) ||
                  (s_axis_tuser_i == FUNC_CLEAR && in_lo != in_hi);
          if (s_axis_tuser_i <= FUNC_CHK_ALL && s_axis_tuser_i != FUNC_CHK_POINT &&
              in_lo > in_hi) begin
            rej_d = STATUS_BOUNDS; upd_d = 1'b0; state_d = S_DONE;
          end else if (s_axis_tuser_i > FUNC_CHK_ALL ||
                       (s_axis_tuser_i == FUNC_CLEAR && in_lo == in_hi)) begin
            state_d = S_DONE;
          end else if (count_q == '0) begin
            state_d = S_FIN;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        re = 1'b1;
        state_d = S_PROC;
      end
      S_PROC: begin
        hit_d = hit_q | step.hit;
        if (step.merge) begin
          if (s_w < ms_q) ms_d = s_w;
          if (e_w > me_q) me_d = e_w;
        end
        if (step.place) placed_d = 1'b1;
        if (step.wr0) begin
          we = 1'b1;
          wdata = pick(step.src0, s_w, e_w, ms_q, me_q, lo_q, hi_q);
          n_d = n_q + 1'b1;
        end
        wr2_d = pick(step.src1, s_w, e_w, ms_q, me_q, lo_q, hi_q);
        if (step.wr1) begin
          state_d = S_WR2;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = (idx_q + 1'b1 == N_W'(count_q)) ? S_FIN : S_RD;
        end
      end
      S_WR2: begin
        we = 1'b1;
        wdata = wr2_q;
        n_d = n_q + 1'b1;
        idx_d = idx_q + 1'b1;
        state_d = (idx_q + 1'b1 == N_W'(count_q)) ? S_FIN : S_RD;
      end
      S_FIN: begin
        if (func_q == FUNC_FILL && !placed_q) begin
          we = 1'b1;
          wdata = {me_q, ms_q};
          n_d = n_q + 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (upd_q && upd_ok) begin
            count_d = CNT_W'(n_q);
            bank_d = !bank_q;
          end
          out_d[0] = upd_q ? 1'b0 : hit_q;
          out_d[2:1] = (upd_q && !upd_ok) ? STATUS_FULL : rej_q;
          out_d[OUT_W-1:3] = (upd_q && upd_ok) ? CNT_W'(n_q) : count_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // entries beyond capacity are dropped; the update is refused later
    if (n_q >= N_W'(MAX_RANGES)) we = 1'b0;
  end

  assign raddr = {bank_q, idx_q[IDX_W-1:0]};
  assign waddr = {!bank_q, n_q[IDX_W-1:0]};

  // interval memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      bank_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      bank_q <= bank_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    func_q <= func_d; lo_q <= lo_d; hi_q <= hi_d;
    ms_q <= ms_d; me_q <= me_d; placed_q <= placed_d; hit_q <= hit_d;
    upd_q <= upd_d; rej_q <= rej_d; idx_q <= idx_d; n_q <= n_d;
    wr2_q <= wr2_d; out_q <= out_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = TD_W'(out_q);

  // checks
  `ASSERT_CLK(a_count_range, clk_i, rst_ni, count_q <= CNT_W'(MAX_RANGES), "count over capacity")
  `ASSERT_IMP(a_busy_after_req, clk_i, rst_ni, in_acc, ##1 (state_q != S_IDLE), "request not taken")
  `ASSERT_IMP(a_refused_no_answer, clk_i, rst_ni, out_valid_q && out_q[2:1] != STATUS_OK, out_q[0] == 1'b0, "refused item answered")
  `ASSERT_IMP(a_write_in_range, clk_i, rst_ni, we, n_q < N_W'(MAX_RANGES), "write past capacity")

endmodule
`default_nettype wire

// ----- rtl/dit_step.sv -----
// per-entry decision logic for fill, clear and queries
`timescale 1ns / 1ps
`default_nettype none
module dit_step #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic [2:0]             func_i,
  input  wire logic [COORD_WIDTH-1:0] lo_i,
  input  wire logic [COORD_WIDTH-1:0] hi_i,
  input  wire logic                   placed_i,
  input  wire logic [COORD_WIDTH-1:0] s_i,
  input  wire logic [COORD_WIDTH-1:0] e_i,
  output dit_pkg::step_t              step_o
);
  import dit_pkg::*;

  // classify the entry against the request
  always_comb begin
    step_o = '0;
    step_o.src0 = SRC_ENTRY;
    step_o.src1 = SRC_ENTRY;
    unique case (func_i)
      FUNC_FILL: begin
        if (e_i < lo_i) begin
          step_o.wr0 = 1'b1;
        end else if (s_i > hi_i) begin
          step_o.wr0 = 1'b1;
          if (!placed_i) begin
            step_o.src0  = SRC_MERGED;
            step_o.place = 1'b1;
            step_o.wr1   = 1'b1;
          end
        end else begin
          step_o.merge = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        if (e_i <= lo_i || s_i >= hi_i) begin
          step_o.wr0 = 1'b1;
        end else if (s_i <= lo_i) begin
          step_o.wr0  = 1'b1;
          step_o.src0 = SRC_LEFT;
          step_o.wr1  = (e_i >= hi_i);
          step_o.src1 = SRC_RIGHT;
        end else if (e_i >= hi_i) begin
          step_o.wr0  = 1'b1;
          step_o.src0 = SRC_RIGHT;
        end
      end
      FUNC_CHK_POINT: step_o.hit = (s_i <= lo_i) && (e_i >= lo_i);
      FUNC_CHK_ANY:   step_o.hit = (s_i <= hi_i) && (e_i >= lo_i);
      FUNC_CHK_ALL:   step_o.hit = (s_i <= lo_i) && (e_i >= hi_i);
      default: ;
    endcase
  end

endmodule
`default_nettype wire
